// File: rtl/fractal_value_noise_sampler_assert.svh
// Assertion macros used by the file that checks its own logic.
`ifndef FRACTAL_VALUE_NOISE_SAMPLER_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_SAMPLER_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle.
`define FVNS_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define FVNS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fvns_pkg.sv
package fvns_pkg;

   localparam int GRID_LOG2 = 7;
   localparam int CW        = GRID_LOG2;
   localparam int ADDR_W    = 2 * CW;
   localparam int MAX_OCT   = 8;
   localparam int KW        = 3;
   localparam int FW        = 8;
   localparam int WW        = 2 * FW;
   localparam int SAMPLE_W  = 16;
   localparam int NUM_W     = 32;
   localparam int AMP_W     = 32;
   localparam int SUM_W     = 51;
   localparam int TOT_W     = 35;
   localparam int DVD_W     = SUM_W;
   localparam int DVS_W     = TOT_W;

   localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);
   localparam logic [AMP_W-1:0] AMP_MAX = '1;

   localparam logic [3:0]  OCT_RESET  = 4'd4;
   localparam logic [15:0] BIAS_RESET = 16'd8192;

   localparam logic CSR_OCTAVE_COUNT = 1'b0;
   localparam logic CSR_BIAS         = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic       write;
      logic       load;
      logic       setup;
      logic       rd_en;
      logic [1:0] rd_corner;
      logic       acc_en;
      logic [1:0] acc_corner;
      logic       accum;
      logic       amp_start;
      logic       amp_update;
      logic       fin_start;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_octave;
      logic out_free;
   } status_type;

endpackage

// File: rtl/fvns_div.sv
module fvns_div
   import fvns_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;

   // One restoring step per cycle, quotient bits shift in from the bottom.
   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DVD_W);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/fvns_datapath.sv
module fvns_datapath
   import fvns_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [6:0]          req_row,
   input  logic [6:0]          req_col,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_value
);

   logic [SAMPLE_W-1:0] grid_mem [2**ADDR_W];
   logic [SAMPLE_W-1:0] rd_ff;

   logic [3:0]  oct_cnt_ff;
   logic [15:0] bias_ff;
   logic [KW-1:0] last_k_ff;

   logic [CW-1:0]    row_ff, col_ff;
   logic [KW-1:0]    k_ff;
   logic [WW-1:0]    w_ff [4];
   logic [WW-1:0]    w_in [4];
   logic [NUM_W-1:0] num_ff;
   logic [AMP_W-1:0] amp_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [TOT_W-1:0] tot_ff;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_value_ff;

   logic [15:0]      lowmask;
   logic [CW-1:0]    r0, c0, r1, c1, p_c;
   logic [FW-1:0]    h, v, ph, pv, p8;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [15:0]      oct_val;
   logic [KW:0]      n_clamped;
   logic [15:0]      bias_eff;

   logic             div_start, div_done;
   logic [DVD_W-1:0] div_dvd, div_q;
   logic [DVS_W-1:0] div_dvs;

   // Lattice geometry of the current octave.
   always_comb begin
      lowmask = (16'd1 << k_ff) - 16'd1;
      p_c     = CW'(16'd1 << k_ff);
      p8      = FW'(16'd1 << k_ff);
      r0      = row_ff & ~lowmask[CW-1:0];
      c0      = col_ff & ~lowmask[CW-1:0];
      r1      = r0 + p_c;
      c1      = c0 + p_c;
      h       = FW'(16'(row_ff) & lowmask);
      v       = FW'(16'(col_ff) & lowmask);
      ph      = p8 - h;
      pv      = p8 - v;
      w_in[0] = WW'(ph * pv);
      w_in[1] = WW'(h * pv);
      w_in[2] = WW'(ph * v);
      w_in[3] = WW'(h * v);
      rd_addr = {cmd.rd_corner[0] ? r1 : r0, cmd.rd_corner[1] ? c1 : c0};
      wr_addr = {CW'(req_row), CW'(req_col)};
      oct_val = 16'(num_ff >> {k_ff, 1'b0});
   end

   // Octave count clamped to 1..8 and bias zero taken as one.
   always_comb begin
      if (oct_cnt_ff == 4'd0)
         n_clamped = (KW+1)'(1);
      else if (oct_cnt_ff > 4'(MAX_OCT))
         n_clamped = (KW+1)'(MAX_OCT);
      else
         n_clamped = (KW+1)'(oct_cnt_ff);
      bias_eff = (bias_ff == 16'd0) ? 16'd1 : bias_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.write) grid_mem[wr_addr] <= req_sample;
      if (cmd.rd_en) rd_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cnt_ff <= OCT_RESET;
         bias_ff    <= BIAS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OCTAVE_COUNT: oct_cnt_ff <= csr_wdata[3:0];
            CSR_BIAS:         bias_ff    <= csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff    <= CW'(req_row);
         col_ff    <= CW'(req_col);
         k_ff      <= '0;
         amp_ff    <= AMP_ONE;
         sum_ff    <= '0;
         tot_ff    <= '0;
         last_k_ff <= KW'(n_clamped - 1'b1);
      end
      if (cmd.setup) begin
         for (int i = 0; i < 4; i++) w_ff[i] <= w_in[i];
         num_ff <= '0;
      end
      if (cmd.acc_en) num_ff <= num_ff + NUM_W'(w_ff[cmd.acc_corner] * rd_ff);
      if (cmd.accum) begin
         sum_ff <= sum_ff + SUM_W'(amp_ff * oct_val);
         tot_ff <= tot_ff + TOT_W'(amp_ff);
      end
      if (cmd.amp_update) begin
         amp_ff <= (|div_q[DVD_W-1:AMP_W]) ? AMP_MAX : div_q[AMP_W-1:0];
         k_ff   <= k_ff + 1'b1;
      end
      if (cmd.out_load) rsp_value_ff <= div_q[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   // The amplitude step and the final normalization share one divider.
   assign div_start = cmd.amp_start | cmd.fin_start;
   assign div_dvd   = cmd.fin_start ? sum_ff : DVD_W'({amp_ff, 12'd0});
   assign div_dvs   = cmd.fin_start ? tot_ff : DVS_W'(bias_eff);

   fvns_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.div_done    = div_done;
   assign status.last_octave = (k_ff == last_k_ff);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;

endmodule

// File: rtl/fvns_ctrl.sv
module fvns_ctrl
   import fvns_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SETUP    = 8'b0000_0010,
      ST_READ     = 8'b0000_0100,
      ST_ACCUM    = 8'b0000_1000,
      ST_AMPDIV   = 8'b0001_0000,
      ST_FINSTART = 8'b0010_0000,
      ST_FINDIV   = 8'b0100_0000,
      ST_FIN      = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_QUERY) begin
                  cmd.load = 1'b1;
                  state_in = ST_SETUP;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = 3'd0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            // Each corner read is issued in the cycle before its accumulation.
            cmd.rd_en      = (cnt_ff != 3'd4);
            cmd.rd_corner  = cnt_ff[1:0];
            cmd.acc_en     = (cnt_ff != 3'd0);
            cmd.acc_corner = 2'(cnt_ff - 3'd1);
            cnt_in         = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.last_octave) begin
               state_in = ST_FINSTART;
            end else begin
               cmd.amp_start = 1'b1;
               state_in      = ST_AMPDIV;
            end
         end
         ST_AMPDIV: begin
            if (status.div_done) begin
               cmd.amp_update = 1'b1;
               state_in       = ST_SETUP;
            end
         end
         ST_FINSTART: begin
            cmd.fin_start = 1'b1;
            state_in      = ST_FINDIV;
         end
         ST_FINDIV: begin
            if (status.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/fractal_value_noise_sampler.sv
// Fractal value noise sampler.
// The req channel carries one word per operation: op 0 stores sample at
// (row, col) of a 128 by 128 grid, op 1 queries the smoothed value of that
// cell. Writes finish in the cycle they are accepted and give no rsp word.
// A query gives exactly one rsp word carrying value, the normalized sum of
// n octaves of bilinear value noise, n set by the octave count register.
// Every octave runs setup, four corner reads and the accumulate, then the
// amplitude division; the last octave skips the amplitude step and is
// followed by the normalization division, which gives the rsp word.
// One restoring divider, 51 steps long, serves both divisions.
// Only one query is in flight; req_stall is high while it runs, and the
// next word can be accepted in the cycle after the rsp word is loaded.
// The rsp word sits in an output register, so a new word may be accepted
// on req while a finished result waits under rsp_stall; a second query
// holds its result until the first one has been taken.
// Reset clears control state and loads octave count 4 and bias 2.0; grid
// contents are undefined until written. Write csr registers only when idle.
module fractal_value_noise_sampler
   import fvns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [6:0]  req_row,
   input  logic [6:0]  req_col,
   input  logic [15:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_value,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

`include "fractal_value_noise_sampler_assert.svh"

   // Commands flow from the sequencer to the datapath, status comes back.
   cmd_type    cmd;
   status_type status;

   fvns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fvns_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_sample (req_sample),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value)
   );

   // An accepted query keeps the block busy in the following cycle.
   `FVNS_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && !req_stall && req_op == OP_QUERY, req_stall, "query did not occupy the block")
   // A write finishes in the cycle it is accepted and leaves the block ready.
   `FVNS_ASSERT_NEXT(a_write_single, clock, reset, req_valid && !req_stall && req_op == OP_WRITE, !req_stall, "write left the block busy")
   // A result only appears at the end of a running query.
   `FVNS_ASSERT_SAME(a_rsp_from_query, clock, reset, $rose(rsp_valid), $past(req_stall), "result without a running query")

endmodule
